/* hw/rtl/tcw_pkg.sv */
// shared types, constants and reset values of the cubic window block
package tcw_pkg;

  // widths of the shared arithmetic unit
  localparam int unsigned AluW     = 96;
  localparam int unsigned DivisorW = 49;
  localparam int unsigned MulSteps = 32;
  localparam int unsigned DivSteps = 96;
  localparam int unsigned StepCntW = 7;

  // burst limit per ack
  localparam int unsigned MaxBurst   = 16;
  localparam int unsigned BurstLimit = (MaxBurst < 16) ? MaxBurst : 16;
  localparam int unsigned BurstCntW  = $clog2(BurstLimit + 1);

  // register indexes
  localparam logic [2:0] CFG_SEGMENT_SIZE = 3'd0;
  localparam logic [2:0] CFG_CUBIC_GAIN   = 3'd1;
  localparam logic [2:0] CFG_BACKOFF      = 3'd2;
  localparam logic [2:0] CFG_DUP_THRESH   = 3'd5;

  // reset values
  localparam logic [15:0] MssReset    = 16'd1460;
  localparam logic [15:0] GainReset   = 16'd26214;
  localparam logic [15:0] BetaReset   = 16'd45875;
  localparam logic [2:0]  DupThReset  = 3'd3;
  localparam logic [47:0] WindowReset = {32'd14600, 16'd0};
  localparam logic [47:0] ThreshReset = {32'd65535, 16'd0};

  localparam logic [47:0]           WinSat   = 48'hFFFF_FFFF_FFFF;
  // us to q16 seconds: s * 2^16 / 1e6 = s * 2^10 / 15625, taken as
  // (s * UsRecip) >> 56 with UsRecip = ceil(2^56 / 15625) * 2^10, exact for 32 bit s
  localparam logic [52:0]           UsRecip  = 53'd4722366482870272;
  localparam logic [2:0]            DupSat   = 3'd7;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

endpackage

/* hw/rtl/tcw_alu.sv */
// shared shift-add multiplier and restoring divider, one bit per cycle
module tcw_alu (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  tcw_pkg::alu_req_t                    req_i,
  input  logic [tcw_pkg::AluW-1:0]             opa_i,
  input  logic [tcw_pkg::DivisorW-1:0]         opb_i,
  output logic                                 done_o,
  output logic [tcw_pkg::AluW-1:0]             res_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  tcw_pkg::alu_op_e                  op_q, op_d;
  logic [tcw_pkg::StepCntW-1:0]      cnt_q, cnt_d;
  logic [tcw_pkg::AluW-1:0]          acc_q, acc_d;
  logic [63:0]                       mcand_q, mcand_d;
  logic [31:0]                       mplier_q, mplier_d;
  logic [tcw_pkg::DivisorW-1:0]      rem_q, rem_d;
  logic [tcw_pkg::DivisorW-1:0]      dvs_q, dvs_d;
  logic [tcw_pkg::DivisorW:0]        trial;
  logic                              ge;

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    op_d     = op_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    rem_d    = rem_q;
    dvs_d    = dvs_q;
    trial    = {rem_q, acc_q[tcw_pkg::AluW-1]};
    ge       = trial >= {1'b0, dvs_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      if (req_i.op == tcw_pkg::ALU_MUL) begin
        cnt_d    = tcw_pkg::StepCntW'(tcw_pkg::MulSteps);
        acc_d    = '0;
        mcand_d  = opa_i[63:0];
        mplier_d = opb_i[31:0];
      end else begin
        cnt_d = tcw_pkg::StepCntW'(tcw_pkg::DivSteps);
        acc_d = opa_i;
        rem_d = '0;
        dvs_d = opb_i;
      end
    end else if (busy_q) begin
      if (op_q == tcw_pkg::ALU_MUL) begin
        acc_d    = {acc_q[tcw_pkg::AluW-2:0], 1'b0}
                 + (mplier_q[31] ? {32'd0, mcand_q} : '0);
        mplier_d = {mplier_q[30:0], 1'b0};
      end else begin
        rem_d = ge ? tcw_pkg::DivisorW'(trial - {1'b0, dvs_q})
                   : trial[tcw_pkg::DivisorW-1:0];
        acc_d = {acc_q[tcw_pkg::AluW-2:0], ge};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == tcw_pkg::StepCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= tcw_pkg::ALU_MUL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    rem_q    <= rem_d;
    dvs_q    <= dvs_d;
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

/* hw/rtl/tcp_cubic_window_unit.sv */
// top level: cubic congestion window sequencer around one shared arithmetic unit
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------------
//  in      | sink      | in_valid_i / in_ready_o   | operation, ack_number, now_us
//  out     | source    | out_valid_o / out_ready_i | send_valid, send_seq, retransmit,
//          |           |                           | window_bytes, loss_total, last
//  cfg     | sink      | cfg_we_i (no wait)        | cfg_index_i, cfg_data_i
//
// one item at a time: in_ready_o is high only while the sequencer is idle
// open, old or duplicate ack: a decode state then a result state; a loss adds one or two
//   multiplies; sends leave one per cycle, up to 16 per ack, while the sink takes them
// cubic growth: a cube term (four multiplies), a multiply and a divide
// a new epoch below window_max first searches K in 32 steps of one term each
// reset clears state at once, no clearing pass; a stalled output simply holds the sequencer
module tcp_cubic_window_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [31:0] ack_number_i,
  input  logic [31:0] now_us_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        send_valid_o,
  output logic [31:0] send_seq_o,
  output logic        retransmit_o,
  output logic [31:0] window_bytes_o,
  output logic [31:0] loss_total_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  // sequencer states
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DISP   = 5'd1;
  localparam logic [4:0] S_EMIT   = 5'd2;
  localparam logic [4:0] S_SEND   = 5'd3;
  localparam logic [4:0] S_CSTART = 5'd4;
  localparam logic [4:0] S_KSTEP  = 5'd5;
  localparam logic [4:0] S_TDIV   = 5'd6;
  localparam logic [4:0] S_TM1    = 5'd7;
  localparam logic [4:0] S_TM2    = 5'd8;
  localparam logic [4:0] S_TM3    = 5'd9;
  localparam logic [4:0] S_KCMP   = 5'd10;
  localparam logic [4:0] S_CELAP  = 5'd11;
  localparam logic [4:0] S_CTGT   = 5'd12;
  localparam logic [4:0] S_GMUL   = 5'd13;
  localparam logic [4:0] S_GDIV   = 5'd14;
  localparam logic [4:0] S_LWMAX  = 5'd15;
  localparam logic [4:0] S_LBETA  = 5'd16;

  localparam int unsigned NW = tcw_pkg::BurstCntW;

  // configuration
  logic [15:0] mss_q, gain_q, beta_q;
  logic [2:0]  dupth_q;

  // flow state
  logic [47:0] win_q, win_d, thr_q, thr_d, wmax_q, wmax_d;
  logic [31:0] nseq_q, nseq_d, hack_q, hack_d;
  logic [2:0]  dup_q, dup_d;
  logic        epv_q, epv_d;
  logic [31:0] eps_q, eps_d, kinf_q, kinf_d, loss_q, loss_d;

  // sequencer control
  logic [4:0]    state_q, state_d;
  logic          go_q;
  logic [NW-1:0] n_q, n_d;
  logic          ksrch_q, ksrch_d;
  logic          sq_q, sq_d;
  logic          neg_q, neg_d;
  logic [4:0]    bit_q, bit_d;

  // working values
  logic        op_q, op_d;
  logic [31:0] ack_q, ack_d, now_q, now_d;
  logic [31:0] s_q, s_d, k_q, k_d;
  logic [28:0] t_q, t_d;
  logic [57:0] t2_q, t2_d;
  logic [54:0] t3_q, t3_d, term_q, term_d;
  logic [47:0] diff_q, diff_d;
  logic [55:0] dg_q, dg_d;
  logic        emv_q, emv_d, emr_q, emr_d;
  logic [31:0] ems_q, ems_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic        sv_q, sv_d, rt_q, rt_d, last_q, last_d;
  logic [31:0] seq_q, seq_d, wb_q, wb_d, lt_q, lt_d;
  logic        out_free;

  // arithmetic unit
  tcw_pkg::alu_req_t               alu_req;
  logic [tcw_pkg::AluW-1:0]        alu_a, alu_res;
  logic [tcw_pkg::DivisorW-1:0]    alu_b;
  logic                            alu_done;

  // combinational helpers
  logic [31:0] wint, xdist, elapsed, bitmask;
  logic [32:0] sum1, sum2, dsgn;
  logic        cond_now, more;
  logic [56:0] tgt;
  logic        tgt_gt;
  logic [47:0] inc, floor2, bval;
  logic [48:0] gsum, ssum;
  logic [2:0]  dup_new;

  tcw_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .opa_i  (alu_a),
    .opb_i  (alu_b),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  assign out_free = !out_valid_q || out_ready_i;

  // operand selection for the shared unit
  always_comb begin
    alu_req.start = 1'b0;
    alu_req.op    = tcw_pkg::ALU_MUL;
    alu_a         = '0;
    alu_b         = '0;
    unique case (state_q)
      S_TDIV: begin
        // q16 seconds by reciprocal multiply, quotient sits at bit 56
        alu_req.start = go_q;
        alu_a         = {43'd0, tcw_pkg::UsRecip};
        alu_b         = {17'd0, s_q};
      end
      S_TM1: begin
        alu_req.start = go_q;
        alu_a         = {67'd0, t_q};
        alu_b         = {20'd0, t_q};
      end
      S_TM2: begin
        alu_req.start = go_q;
        alu_a         = {38'd0, t2_q};
        alu_b         = {20'd0, t_q};
      end
      S_TM3: begin
        alu_req.start = go_q;
        alu_a         = {41'd0, t3_q};
        alu_b         = {33'd0, gain_q};
      end
      S_GMUL: begin
        alu_req.start = go_q;
        alu_a         = sq_q ? {80'd0, mss_q} : {40'd0, dg_q};
        alu_b         = sq_q ? {33'd0, mss_q} : {17'd0, mss_q, 16'd0};
      end
      S_GDIV: begin
        // square of mss scaled by 2^32 when the target is not above the window
        alu_req.start = go_q;
        alu_req.op    = tcw_pkg::ALU_DIV;
        alu_a         = sq_q ? {alu_res[63:0], 32'd0} : alu_res;
        alu_b         = (win_q == '0) ? tcw_pkg::DivisorW'(1) : {1'b0, win_q};
      end
      S_LWMAX: begin
        alu_req.start = go_q;
        alu_a         = {48'd0, win_q};
        alu_b         = {32'd0, 1'b1, beta_q};
      end
      S_LBETA: begin
        alu_req.start = go_q;
        alu_a         = {48'd0, win_q};
        alu_b         = {33'd0, beta_q};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    // send window check for the current and the following segment
    wint     = win_q[47:16];
    xdist    = nseq_q - hack_q;
    sum1     = {1'b0, xdist} + {17'd0, mss_q};
    cond_now = sum1 <= {1'b0, wint};
    sum2     = {1'b0, sum1[31:0]} + {17'd0, mss_q};
    more     = (sum2 <= {1'b0, wint}) && (n_q < NW'(tcw_pkg::BurstLimit - 1));

    elapsed  = now_q - eps_q;
    dsgn     = {1'b0, elapsed} - {1'b0, kinf_q};
    bitmask  = 32'd1 << bit_q;

    tgt      = neg_q ? ({9'd0, wmax_q} - {2'd0, term_q}) : ({9'd0, wmax_q} + {2'd0, term_q});
    tgt_gt   = !tgt[56] && (tgt[55:0] > {8'd0, win_q});

    inc      = (|alu_res[95:48]) ? tcw_pkg::WinSat : alu_res[47:0];
    gsum     = {1'b0, win_q} + {1'b0, inc};
    ssum     = {1'b0, win_q} + {17'd0, mss_q, 16'd0};
    floor2   = {15'd0, mss_q, 17'd0};
    bval     = alu_res[63:16];
    dup_new  = (dup_q == tcw_pkg::DupSat) ? tcw_pkg::DupSat : dup_q + 3'd1;

    state_d = state_q;
    win_d = win_q;  thr_d = thr_q;  wmax_d = wmax_q;
    nseq_d = nseq_q;  hack_d = hack_q;  dup_d = dup_q;
    epv_d = epv_q;  eps_d = eps_q;  kinf_d = kinf_q;  loss_d = loss_q;
    n_d = n_q;  ksrch_d = ksrch_q;  sq_d = sq_q;  neg_d = neg_q;  bit_d = bit_q;
    op_d = op_q;  ack_d = ack_q;  now_d = now_q;
    s_d = s_q;  k_d = k_q;  t_d = t_q;  t2_d = t2_q;  t3_d = t3_q;  term_d = term_q;
    diff_d = diff_q;  dg_d = dg_q;
    emv_d = emv_q;  emr_d = emr_q;  ems_d = ems_q;
    sv_d = sv_q;  rt_d = rt_q;  last_d = last_q;  seq_d = seq_q;  wb_d = wb_q;  lt_d = lt_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = operation_i;
          ack_d   = ack_number_i;
          now_d   = now_us_i;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        emv_d   = 1'b0;
        emr_d   = 1'b0;
        ems_d   = '0;
        state_d = S_EMIT;
        if (op_q) begin
          emv_d  = 1'b1;
          ems_d  = nseq_q;
          nseq_d = nseq_q + {16'd0, mss_q};
        end else if (ack_q > hack_q) begin
          hack_d = ack_q;
          dup_d  = '0;
          n_d    = '0;
          if (win_q < thr_q) begin
            win_d   = ssum[48] ? tcw_pkg::WinSat : ssum[47:0];
            state_d = S_SEND;
          end else begin
            state_d = S_CSTART;
          end
        end else if (ack_q == hack_q) begin
          dup_d = dup_new;
          if (dup_new == dupth_q) begin
            // loss: fast retransmit of the acked sequence
            loss_d = loss_q + 32'd1;
            epv_d  = 1'b0;
            emv_d  = 1'b1;
            emr_d  = 1'b1;
            ems_d  = ack_q;
            if (win_q < wmax_q) begin
              state_d = S_LWMAX;
            end else begin
              wmax_d  = win_q;
              state_d = S_LBETA;
            end
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          sv_d        = emv_q;
          seq_d       = ems_q;
          rt_d        = emr_q;
          wb_d        = win_q[47:16];
          lt_d        = loss_q;
          last_d      = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_SEND: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          wb_d        = win_q[47:16];
          lt_d        = loss_q;
          rt_d        = 1'b0;
          if (cond_now) begin
            sv_d   = 1'b1;
            seq_d  = nseq_q;
            last_d = !more;
            nseq_d = nseq_q + {16'd0, mss_q};
            n_d    = n_q + NW'(1);
            if (!more) begin
              state_d = S_IDLE;
            end
          end else begin
            // nothing fits in the window: status only
            sv_d    = 1'b0;
            seq_d   = '0;
            last_d  = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      S_CSTART: begin
        ksrch_d = 1'b0;
        state_d = S_CELAP;
        if (!epv_q) begin
          epv_d  = 1'b1;
          eps_d  = now_q;
          kinf_d = '0;
          if (win_q < wmax_q) begin
            diff_d  = wmax_q - win_q;
            k_d     = '0;
            bit_d   = 5'd31;
            ksrch_d = 1'b1;
            state_d = S_KSTEP;
          end
        end
      end
      S_KSTEP: begin
        s_d     = k_q | bitmask;
        state_d = S_TDIV;
      end
      S_TDIV: begin
        if (alu_done) begin
          t_d     = alu_res[84:56];
          state_d = S_TM1;
        end
      end
      S_TM1: begin
        if (alu_done) begin
          t2_d    = alu_res[57:0];
          state_d = S_TM2;
        end
      end
      S_TM2: begin
        if (alu_done) begin
          t3_d    = alu_res[86:32];
          state_d = S_TM3;
        end
      end
      S_TM3: begin
        if (alu_done) begin
          term_d  = alu_res[70:16];
          state_d = ksrch_q ? S_KCMP : S_CTGT;
        end
      end
      S_KCMP: begin
        if (term_q <= {7'd0, diff_q}) begin
          k_d = k_q | bitmask;
        end
        if (bit_q == 5'd0) begin
          kinf_d  = (term_q <= {7'd0, diff_q}) ? (k_q | bitmask) : k_q;
          ksrch_d = 1'b0;
          state_d = S_CELAP;
        end else begin
          bit_d   = bit_q - 5'd1;
          state_d = S_KSTEP;
        end
      end
      S_CELAP: begin
        neg_d   = dsgn[32];
        s_d     = dsgn[32] ? (~dsgn[31:0] + 32'd1) : dsgn[31:0];
        state_d = S_TDIV;
      end
      S_CTGT: begin
        sq_d    = !tgt_gt;
        dg_d    = tgt[55:0] - {8'd0, win_q};
        state_d = S_GMUL;
      end
      S_GMUL: begin
        if (alu_done) begin
          state_d = S_GDIV;
        end
      end
      S_GDIV: begin
        if (alu_done) begin
          win_d   = gsum[48] ? tcw_pkg::WinSat : gsum[47:0];
          state_d = S_SEND;
        end
      end
      S_LWMAX: begin
        if (alu_done) begin
          wmax_d  = alu_res[64:17];
          state_d = S_LBETA;
        end
      end
      S_LBETA: begin
        if (alu_done) begin
          win_d   = bval;
          thr_d   = (bval < floor2) ? floor2 : bval;
          state_d = S_EMIT;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control, configuration and flow state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      go_q        <= 1'b0;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      ksrch_q     <= 1'b0;
      mss_q       <= tcw_pkg::MssReset;
      gain_q      <= tcw_pkg::GainReset;
      beta_q      <= tcw_pkg::BetaReset;
      dupth_q     <= tcw_pkg::DupThReset;
      win_q       <= tcw_pkg::WindowReset;
      thr_q       <= tcw_pkg::ThreshReset;
      wmax_q      <= '0;
      nseq_q      <= '0;
      hack_q      <= '0;
      dup_q       <= '0;
      epv_q       <= 1'b0;
      eps_q       <= '0;
      kinf_q      <= '0;
      loss_q      <= '0;
    end else begin
      state_q     <= state_d;
      go_q        <= state_d != state_q;
      out_valid_q <= out_valid_d;
      n_q         <= n_d;
      ksrch_q     <= ksrch_d;
      win_q       <= win_d;
      thr_q       <= thr_d;
      wmax_q      <= wmax_d;
      nseq_q      <= nseq_d;
      hack_q      <= hack_d;
      dup_q       <= dup_d;
      epv_q       <= epv_d;
      eps_q       <= eps_d;
      kinf_q      <= kinf_d;
      loss_q      <= loss_d;
      // initial window and threshold act only through reset, so no storage
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          tcw_pkg::CFG_SEGMENT_SIZE: mss_q   <= cfg_data_i[15:0];
          tcw_pkg::CFG_CUBIC_GAIN:   gain_q  <= cfg_data_i[15:0];
          tcw_pkg::CFG_BACKOFF:      beta_q  <= cfg_data_i[15:0];
          tcw_pkg::CFG_DUP_THRESH:   dupth_q <= cfg_data_i[2:0];
          default: begin
          end
        endcase
      end
    end
  end

  // working and output payload
  always_ff @(posedge clk_i) begin
    sq_q   <= sq_d;
    neg_q  <= neg_d;
    bit_q  <= bit_d;
    op_q   <= op_d;
    ack_q  <= ack_d;
    now_q  <= now_d;
    s_q    <= s_d;
    k_q    <= k_d;
    t_q    <= t_d;
    t2_q   <= t2_d;
    t3_q   <= t3_d;
    term_q <= term_d;
    diff_q <= diff_d;
    dg_q   <= dg_d;
    emv_q  <= emv_d;
    emr_q  <= emr_d;
    ems_q  <= ems_d;
    sv_q   <= sv_d;
    rt_q   <= rt_d;
    last_q <= last_d;
    seq_q  <= seq_d;
    wb_q   <= wb_d;
    lt_q   <= lt_d;
  end

  assign in_ready_o     = state_q == S_IDLE;
  assign out_valid_o    = out_valid_q;
  assign send_valid_o   = sv_q;
  assign send_seq_o     = seq_q;
  assign retransmit_o   = rt_q;
  assign window_bytes_o = wb_q;
  assign loss_total_o   = lt_q;
  assign last_o         = last_q;

endmodule

/* hw/rtl/tcw_checker.sv */
// port level checks of the cubic window block and their binding
module tcw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        send_valid_o,
  input logic [31:0] send_seq_o,
  input logic        retransmit_o,
  input logic        last_o
);

  // a result waiting for the sink holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // one item at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accepting an item");

  // more results of the same item still to come
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("ready before final result");

  // a status result is alone and blank
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !send_valid_o |-> last_o && send_seq_o == 32'd0 && !retransmit_o)
    else $error("malformed status result");

  // a retransmit is a send and the only result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && retransmit_o |-> send_valid_o && last_o)
    else $error("malformed retransmit");

endmodule

bind tcp_cubic_window_unit tcw_checker u_tcw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .send_valid_o (send_valid_o),
  .send_seq_o   (send_seq_o),
  .retransmit_o (retransmit_o),
  .last_o       (last_o)
);
